>>> sv/blr_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
// Depends on nothing; imported by bresenham_line_raster.
`default_nettype none

package blr_pkg;

    localparam int PIX_W              = 12;
    localparam int COLOUR_W           = 32;
    localparam int DEFAULT_COORD_BITS = 12;

    // Command codes carried on the cmd field.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0]    x;
        logic [PIX_W-1:0]    y;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } t_pixel;

endpackage

`default_nettype wire

>>> sv/bresenham_line_raster.sv
// Bresenham line rasterizer for all octants, one beat in and at most one beat out.
// Depends on blr_pkg for field widths, command codes and the pixel struct.
//
// Usage:
//   Input channel (i_valid / o_stall): a beat with cmd = start loads two
//   endpoints and a colour and emits nothing; a start while a line is running
//   drops that line. A beat with cmd = step emits the next pixel of the line,
//   or nothing when no line is loaded.
//   Output channel (o_valid / i_stall): one beat per pixel with x, y, colour
//   and a last flag on the final pixel. After the last pixel the block is idle.
// Timing and throughput:
//   The pixel of an accepted step beat is registered in the output register,
//   or in the skid register while the receiver stalls. One beat is accepted
//   per cycle while o_stall is low, so a line then streams at one pixel per clock.
// Stalls:
//   A skid register behind the output register catches one pixel while the
//   receiver stalls; o_stall rises only when that skid register is full.
// Reset:
//   i_rst_n (synchronous, active low) leaves the block idle with both output
//   registers empty; no line is loaded.
`default_nettype none

module bresenham_line_raster #(
    parameter int COORD_BITS = blr_pkg::DEFAULT_COORD_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_cmd,
    input  wire logic [blr_pkg::PIX_W-1:0]   i_start_x,
    input  wire logic [blr_pkg::PIX_W-1:0]   i_start_y,
    input  wire logic [blr_pkg::PIX_W-1:0]   i_end_x,
    input  wire logic [blr_pkg::PIX_W-1:0]   i_end_y,
    input  wire logic [blr_pkg::COLOUR_W-1:0] i_colour_in,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [blr_pkg::PIX_W-1:0]        o_pixel_x,
    output logic [blr_pkg::PIX_W-1:0]        o_pixel_y,
    output logic [blr_pkg::COLOUR_W-1:0]     o_pixel_colour,
    output logic                             o_last_pixel
);
    import blr_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int ACC_W = COORD_BITS + 3;

    // Line state.
    logic [C-1:0]              r_major_pos, n_major_pos;
    logic [C-1:0]              r_major_end, n_major_end;
    logic [C-1:0]              r_minor_pos, n_minor_pos;
    logic signed [ACC_W-1:0]   r_error_acc, n_error_acc;
    logic [C:0]                r_error_inc, n_error_inc;
    logic [C:0]                r_error_dec, n_error_dec;
    logic [C-1:0]              r_major_span, n_major_span;
    logic                      r_axes_swapped, n_axes_swapped;
    logic                      r_minor_rising, n_minor_rising;
    logic [COLOUR_W-1:0]       r_held_colour, n_held_colour;
    logic                      r_busy, n_busy;

    // Output register and skid register.
    t_pixel                    r_out, n_out;
    logic                      r_out_valid, n_out_valid;
    t_pixel                    r_skid, n_skid;
    logic                      r_skid_valid, n_skid_valid;

    logic                      in_beat;
    logic                      step_fire;
    logic                      load_fire;
    logic                      last;
    t_pixel                    pix;

    // Start decode.
    logic [C-1:0]              ax, ay, bx, by;
    logic [C-1:0]              dx, dy;
    logic                      steep;
    logic [C-1:0]              maj_a, maj_b, min_a, min_b;
    logic [C-1:0]              maj_lo, maj_hi, min_lo, min_hi;
    logic [C-1:0]              span;
    logic [C-1:0]              minor_delta;

    // Step arithmetic.
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   span_ext;
    logic                      minor_move;

    assign o_stall   = r_skid_valid;
    assign in_beat   = i_valid && !r_skid_valid;
    assign load_fire = in_beat && (i_cmd == CMD_START);
    assign step_fire = in_beat && (i_cmd == CMD_STEP) && r_busy;

    always_comb begin
        ax = C'(i_start_x);
        ay = C'(i_start_y);
        bx = C'(i_end_x);
        by = C'(i_end_y);
        dx = (ax > bx) ? (ax - bx) : (bx - ax);
        dy = (ay > by) ? (ay - by) : (by - ay);
        steep = dx < dy;
        maj_a = steep ? ay : ax;
        maj_b = steep ? by : bx;
        min_a = steep ? ax : ay;
        min_b = steep ? bx : by;
        if (maj_b < maj_a) begin
            maj_lo = maj_b;
            maj_hi = maj_a;
            min_lo = min_b;
            min_hi = min_a;
        end else begin
            maj_lo = maj_a;
            maj_hi = maj_b;
            min_lo = min_a;
            min_hi = min_b;
        end
        span        = maj_hi - maj_lo;
        minor_delta = steep ? dx : dy;
    end

    always_comb begin
        last       = r_major_pos == r_major_end;
        acc_sum    = r_error_acc + $signed({2'b00, r_error_inc});
        span_ext   = $signed({3'b000, r_major_span});
        minor_move = acc_sum > span_ext;

        pix.x      = r_axes_swapped ? PIX_W'(r_minor_pos) : PIX_W'(r_major_pos);
        pix.y      = r_axes_swapped ? PIX_W'(r_major_pos) : PIX_W'(r_minor_pos);
        pix.colour = r_held_colour;
        pix.last   = last;
    end

    always_comb begin
        n_major_pos    = r_major_pos;
        n_major_end    = r_major_end;
        n_minor_pos    = r_minor_pos;
        n_error_acc    = r_error_acc;
        n_error_inc    = r_error_inc;
        n_error_dec    = r_error_dec;
        n_major_span   = r_major_span;
        n_axes_swapped = r_axes_swapped;
        n_minor_rising = r_minor_rising;
        n_held_colour  = r_held_colour;
        n_busy         = r_busy;

        if (load_fire) begin
            n_major_pos    = maj_lo;
            n_major_end    = maj_hi;
            n_minor_pos    = min_lo;
            n_major_span   = span;
            n_error_inc    = {minor_delta, 1'b0};
            n_error_dec    = {span, 1'b0};
            n_error_acc    = '0;
            n_axes_swapped = steep;
            n_minor_rising = min_hi > min_lo;
            n_held_colour  = i_colour_in;
            n_busy         = 1'b1;
        end else if (step_fire) begin
            n_error_acc = acc_sum;
            if (minor_move) begin
                n_minor_pos = r_minor_rising ? (r_minor_pos + 1'b1) : (r_minor_pos - 1'b1);
                n_error_acc = acc_sum - $signed({2'b00, r_error_dec});
            end
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_major_pos = r_major_pos + 1'b1;
            end
        end
    end

    // A new pixel goes to the output register when it is free or drains this
    // cycle, otherwise it parks in the skid register. Input is refused while
    // the skid register is full, so the two never collide.
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;

        if (step_fire) begin
            if (!r_out_valid || !i_stall) begin
                n_out       = pix;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = pix;
                n_skid_valid = 1'b1;
            end
        end else if (r_out_valid && !i_stall) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_major_pos    <= n_major_pos;
        r_major_end    <= n_major_end;
        r_minor_pos    <= n_minor_pos;
        r_error_acc    <= n_error_acc;
        r_error_inc    <= n_error_inc;
        r_error_dec    <= n_error_dec;
        r_major_span   <= n_major_span;
        r_axes_swapped <= n_axes_swapped;
        r_minor_rising <= n_minor_rising;
        r_held_colour  <= n_held_colour;
        r_out          <= n_out;
        r_skid         <= n_skid;
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_x      = r_out.x;
    assign o_pixel_y      = r_out.y;
    assign o_pixel_colour = r_out.colour;
    assign o_last_pixel   = r_out.last;

endmodule

`default_nettype wire
